// ===== hw/rtl/mgq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgq_pkg: shared types and constants of the groove quantizer
// Register indexes, defaults and the divider request/response structs.
// ----------------------------------------------------------------------------
package mgq_pkg;

  localparam int unsigned MaxPointsDefault = 128;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STRENGTH  = 3'd0,
    REG_SWING     = 3'd1,
    REG_TOLERANCE = 3'd2,
    REG_GRID_DIV  = 3'd3,
    REG_GROOVE_EN = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRID_MUL,
    ST_GRID_DIV,
    ST_SWING_DIV,
    ST_SCAN_REQ,
    ST_SCAN_CMP,
    ST_OFF_DIV,
    ST_TOL,
    ST_STR_MUL,
    ST_EXTRACT,
    ST_OUT
  } state_e;

  // Divider request: unsigned dividend over a 7 bit divisor.
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quotient;
    logic [6:0]  remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/mgq_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgq_divider: shared radix-2 restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mgq_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mgq_pkg::div_req_t req_i,
  output mgq_pkg::div_rsp_t rsp_o
);

  logic [47:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [7:0]  trial;

  // one shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[6:0], quo_q[47]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[6:0];

endmodule

// ===== hw/rtl/midi_groove_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_groove_quantizer: grid quantizer with swing, strength and groove table
// Snaps notes toward a 1/div beat grid and rebuilds a groove table from clips.
// ----------------------------------------------------------------------------
// Quantize uses the shared divider for the grid point, again with swing, and once
// more when a groove point is hit, after a scan of the stored groove points;
// extract makes one divider pass. One word in flight at a time; s_axis_tready
// is low from acceptance until the result word is taken.
// Reset: asynchronous, active low; registers to defaults, groove count zero,
// groove RAM contents left undefined.
module midi_groove_quantizer #(
  parameter int unsigned MaxPoints = mgq_pkg::MaxPointsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // [31:0] position
  input  logic                         s_axis_tuser,  // operation
  input  logic                         s_axis_tlast,  // last_note
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // [31:0] quantized_position,
                                                      // [39:32] groove_count
  output logic                         m_axis_tuser,  // snapped
  input  logic                         cfg_we_i,
  input  logic [mgq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mgq_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);

  // configuration
  logic [16:0] strength_q;
  logic [15:0] swing_q, tol_q;
  logic [6:0]  div_q;
  logic        gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= 17'd52429;
      swing_q    <= '0;
      tol_q      <= 16'd16384;
      div_q      <= 7'd4;
      gen_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mgq_pkg::REG_STRENGTH:
          strength_q <= (cfg_data_i > 17'd65536) ? 17'd65536 : cfg_data_i;
        mgq_pkg::REG_SWING:
          swing_q <= (cfg_data_i[15:0] > 16'd32768) ? 16'd32768 : cfg_data_i[15:0];
        mgq_pkg::REG_TOLERANCE:
          tol_q <= (cfg_data_i[15:0] > 16'd32768) ? 16'd32768 :
                   (cfg_data_i[15:0] < 16'd655) ? 16'd655 : cfg_data_i[15:0];
        mgq_pkg::REG_GRID_DIV:
          div_q <= (cfg_data_i[6:0] > 7'd64) ? 7'd64 :
                   (cfg_data_i[6:0] == 7'd0) ? 7'd1 : cfg_data_i[6:0];
        mgq_pkg::REG_GROOVE_EN: gen_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // groove memory
  logic [31:0] gpos_mem [MaxPoints];
  logic [17:0] goff_mem [MaxPoints];
  logic [31:0] rd_pos_q;
  logic [17:0] rd_off_q;
  logic        wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [31:0] wr_pos;
  logic [17:0] wr_off;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      gpos_mem[wr_addr] <= wr_pos;
      goff_mem[wr_addr] <= wr_off;
    end
    rd_pos_q <= gpos_mem[rd_addr];
    rd_off_q <= goff_mem[rd_addr];
  end

  // shared divider
  mgq_pkg::div_req_t dreq;
  mgq_pkg::div_rsp_t drsp;

  mgq_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  mgq_pkg::state_e st_q, st_d;
  logic [31:0] pos_q, pos_d;
  logic        op_q, op_d, last_q, last_d;
  logic [47:0] acc_q, acc_d;          // grid point g, plus offsets
  logic [17:0] best_off_q, best_off_d;
  logic [16:0] best_q, best_d;
  logic        best_hit_q, best_hit_d;
  logic [CntW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic        clip_q, clip_d;
  logic [31:0] res_q, res_d;
  logic        snap_q, snap_d;
  logic [49:0] prod_q, prod_d;        // shared multiplier result
  logic        neg_q, neg_d;
  logic [38:0] n_idx;

  // combinational helpers
  logic signed [49:0] diff;
  logic [48:0]        mag;
  logic signed [49:0] sg;
  logic [48:0]        gd;
  logic [48:0]        offm;
  logic [31:0]        gsat;
  logic signed [49:0] off_s;
  logic [17:0]        offv;
  logic signed [50:0] rr;
  logic [48:0]        q_round;

  assign n_idx = prod_q[38:0];

  always_comb begin
    st_d       = st_q;
    pos_d      = pos_q;
    op_d       = op_q;
    last_d     = last_q;
    acc_d      = acc_q;
    best_off_d = best_off_q;
    best_d     = best_q;
    best_hit_d = best_hit_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    clip_d     = clip_q;
    res_d      = res_q;
    snap_d     = snap_q;
    prod_d     = prod_q;
    neg_d      = neg_q;
    dreq       = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_q[AddrW-1:0];
    rd_addr    = idx_q[AddrW-1:0];
    wr_pos     = '0;
    wr_off     = '0;
    diff       = '0;
    mag        = '0;
    sg         = '0;
    gd         = '0;
    offm       = '0;
    gsat       = '0;
    off_s      = '0;
    offv       = '0;
    rr         = '0;
    q_round    = 49'(drsp.quotient) +
                 49'((drsp.remainder >= (div_q - (div_q >> 1))) && (div_q != 7'd1));
    s_axis_tready = 1'b0;

    unique case (st_q)
      mgq_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          pos_d  = s_axis_tdata;
          op_d   = s_axis_tuser;
          last_d = s_axis_tlast;
          st_d   = mgq_pkg::ST_GRID_MUL;
        end
      end
      // n = (pos*div + 0.5) >> 16
      mgq_pkg::ST_GRID_MUL: begin
        prod_d = 50'(({7'd0, pos_q} * {32'd0, div_q} + 39'd32768) >> 16);
        st_d   = mgq_pkg::ST_GRID_DIV;
      end
      // g = round_half_up(n*65536/div)
      mgq_pkg::ST_GRID_DIV: begin
        if (!drsp.done && prod_q[49]) begin
          dreq.start = 1'b0;
        end
        if (prod_q[49] == 1'b0 && !neg_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = 48'({n_idx[31:0], 16'd0}) + 48'(div_q >> 1);
          dreq.divisor  = div_q;
          neg_d         = 1'b1;
        end else if (drsp.done) begin
          acc_d = drsp.quotient;
          neg_d = 1'b0;
          if (op_q) st_d = mgq_pkg::ST_EXTRACT;
          else if (swing_q != 16'd0 && div_q >= 7'd2) st_d = mgq_pkg::ST_SWING_DIV;
          else st_d = mgq_pkg::ST_SCAN_REQ;
        end
      end
      // swing on even eighths
      mgq_pkg::ST_SWING_DIV: begin
        if (!neg_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = 48'(swing_q) + 48'(div_q >> 1);
          dreq.divisor  = div_q;
          neg_d         = 1'b1;
        end else if (drsp.done) begin
          neg_d = 1'b0;
          if ((({1'b0, pos_q, 1'b0} + 34'd32768) >> 16) % 2 == 0)
            acc_d = acc_q + drsp.quotient;
          st_d = mgq_pkg::ST_SCAN_REQ;
        end
      end
      // start groove scan
      mgq_pkg::ST_SCAN_REQ: begin
        idx_d      = '0;
        best_d     = 17'd65536;
        best_hit_d = 1'b0;
        rd_addr    = '0;
        if (gen_q && cnt_q != '0) st_d = mgq_pkg::ST_SCAN_CMP;
        else st_d = mgq_pkg::ST_TOL;
        neg_d = 1'b0;
      end
      // each stored point is read, then compared
      mgq_pkg::ST_SCAN_CMP: begin
        if (!neg_q) begin
          neg_d = 1'b1;
        end else begin
          sg = $signed({2'b00, acc_q}) - $signed({18'd0, rd_pos_q});
          gd = sg[49] ? 49'(-sg) : 49'(sg);
          if (gd < 49'(best_q)) begin
            best_d     = gd[16:0];
            best_off_d = rd_off_q;
            best_hit_d = 1'b1;
          end
          neg_d = 1'b0;
          idx_d = idx_q + 1'b1;
          rd_addr = AddrW'(idx_q + 1'b1);
          if (idx_q + 1'b1 == cnt_q) st_d = mgq_pkg::ST_OFF_DIV;
        end
      end
      // add round_away(off/div)
      mgq_pkg::ST_OFF_DIV: begin
        if (!best_hit_q) begin
          st_d = mgq_pkg::ST_TOL;
        end else if (!neg_q) begin
          offv          = best_off_q[17] ? 18'(-best_off_q) : best_off_q;
          dreq.start    = 1'b1;
          dreq.dividend = 48'(offv) + 48'(div_q >> 1);
          dreq.divisor  = div_q;
          neg_d         = 1'b1;
        end else if (drsp.done) begin
          neg_d = 1'b0;
          acc_d = best_off_q[17] ? acc_q - drsp.quotient : acc_q + drsp.quotient;
          st_d  = mgq_pkg::ST_TOL;
        end
      end
      // tolerance compare
      mgq_pkg::ST_TOL: begin
        diff = $signed({{2{acc_q[47]}}, acc_q}) - $signed({18'd0, pos_q});
        mag  = diff[49] ? 49'(-diff) : 49'(diff);
        prod_d = 50'(diff);
        if (mag[48:32] != '0 || 56'(mag) * 56'(div_q) > 56'(tol_q)) begin
          res_d  = pos_q;
          snap_d = 1'b0;
          st_d   = mgq_pkg::ST_OUT;
        end else begin
          st_d = mgq_pkg::ST_STR_MUL;
        end
      end
      // r = pos + round_away(diff*strength/65536)
      mgq_pkg::ST_STR_MUL: begin
        mag = prod_q[49] ? 49'(-$signed(prod_q)) : 49'(prod_q);
        q_round = 49'((mag[16:0] * strength_q + 34'd32768) >> 16);
        rr = prod_q[49] ? $signed({19'd0, pos_q}) - $signed({2'b0, q_round})
                        : $signed({19'd0, pos_q}) + $signed({2'b0, q_round});
        if (rr < 0) res_d = '0;
        else if (rr > 51'sh0FFFFFFFF) res_d = 32'hFFFFFFFF;
        else res_d = rr[31:0];
        snap_d = 1'b1;
        st_d   = mgq_pkg::ST_OUT;
      end
      // groove extraction for one clip note
      mgq_pkg::ST_EXTRACT: begin
        res_d  = pos_q;
        snap_d = 1'b0;
        st_d   = mgq_pkg::ST_OUT;
        off_s  = ($signed({18'd0, pos_q}) - $signed({2'b0, acc_q})) *
                 $signed({43'd0, div_q});
        offm   = off_s[49] ? 49'(-off_s) : 49'(off_s);
        gsat   = (acc_q[47:32] != '0) ? 32'hFFFFFFFF : acc_q[31:0];
        if (!(!clip_q && last_q)) begin
          if (!clip_q) begin
            cnt_d  = '0;
            clip_d = 1'b1;
          end
          if (last_q) clip_d = 1'b0;
          if (!clip_q || cnt_q < CntW'(MaxPoints)) begin
            if (offm * 49'd10 > 49'd32768) begin
              wr_en   = 1'b1;
              wr_addr = clip_q ? cnt_q[AddrW-1:0] : '0;
              wr_pos  = gsat;
              wr_off  = off_s[17:0];
              cnt_d   = clip_q ? cnt_q + 1'b1 : CntW'(1);
            end
          end
        end
      end
      mgq_pkg::ST_OUT: begin
        if (m_axis_tready) st_d = mgq_pkg::ST_IDLE;
      end
      default: st_d = mgq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mgq_pkg::ST_IDLE;
      cnt_q  <= '0;
      clip_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      clip_q <= clip_d;
      neg_q  <= neg_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    op_q       <= op_d;
    last_q     <= last_d;
    acc_q      <= acc_d;
    best_off_q <= best_off_d;
    best_q     <= best_d;
    best_hit_q <= best_hit_d;
    res_q      <= res_d;
    snap_q     <= snap_d;
    prod_q     <= prod_d;
  end

  assign m_axis_tvalid = (st_q == mgq_pkg::ST_OUT);
  assign m_axis_tdata  = {8'(cnt_q), res_q};
  assign m_axis_tuser  = snap_q;

endmodule

// ===== hw/rtl/mgq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgq_checker: port-level checks of the groove quantizer
// Watches one-word-in-flight behavior and result field ranges.
// ----------------------------------------------------------------------------
module mgq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // no new word while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

  // accepted word is not answered in the next cycle
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // groove count never exceeds 128
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:32] <= 8'd128) else $error("count range");

  // result fields are known whenever offered
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
    else $error("unknown result bits");

endmodule

bind midi_groove_quantizer mgq_checker u_mgq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== dv/midi_groove_quantizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_groove_quantizer_tb: self-checking bench for the groove quantizer
// Drives quantize and clip-extract words over the input stream and predicts
// each result word with an in-bench model of grid, swing, groove table,
// tolerance and strength. Covers register extremes and clamping, one-note
// clips, table overflow, saturation at both ends, and backpressure.
// ----------------------------------------------------------------------------
module midi_groove_quantizer_tb;

  localparam int unsigned NumPoints = 128;
  localparam longint CycleLimit = 3000000;
  localparam logic [mgq_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam bit OpQuantize = 1'b0;
  localparam bit OpExtract = 1'b1;

  typedef struct {
    bit [31:0] qpos;
    bit        snapped;
    bit [7:0]  count;
  } note_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] position
  logic s_axis_tuser = 1'b0;       // operation
  logic s_axis_tlast = 1'b0;       // last_note
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // [31:0] quantized_position, [39:32] groove_count
  logic m_axis_tuser;              // snapped
  logic cfg_we_i = 1'b0;
  logic [mgq_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mgq_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // Predictor state and register copy
  bit [31:0] grv_pos [NumPoints];
  longint    grv_off [NumPoints];
  int        grv_cnt;
  bit        clip_open;
  longint    m_strength, m_swing, m_tol, m_div;
  bit        m_groove_en;

  note_result_t result_q[$];
  int  err_cnt = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  snaps_seen = 0;
  longint cycles = 0;
  int  long_hold = 0;
  int  burst_left = 1;

  midi_groove_quantizer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: long hold on request, otherwise short random stall runs
  always @(negedge clk_i) begin
    int stall_run;
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      long_hold = long_hold - 1;
    end else if (stall_run > 0) begin
      m_axis_tready <= 1'b0;
      stall_run = stall_run - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_run = $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    note_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        words_checked++;
        if (exp_r.snapped) snaps_seen++;
        if (m_axis_tdata[31:0] !== exp_r.qpos) begin
          $error("quantized_position exp %h got %h", exp_r.qpos, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_r.snapped) begin
          $error("snapped exp %0d got %0d", exp_r.snapped, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[39:32] !== exp_r.count) begin
          $error("groove_count exp %0d got %0d", exp_r.count, m_axis_tdata[39:32]);
          err_cnt++;
        end
      end
    end
  end

  function automatic longint div_away(longint a, longint d);
    longint m, q;
    m = (a < 0) ? -a : a;
    q = (m + d / 2) / d;
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint nearest_grid(longint pos, longint dv);
    longint n;
    n = (pos * dv + 32768) >>> 16;
    return (n * 65536 + dv / 2) / dv;
  endfunction

  function automatic note_result_t predict_note(bit op, bit [31:0] p, bit last);
    note_result_t r;
    longint pos, g, diff, mag, res, best, off, e;
    pos = longint'(p);
    r.qpos = p;
    r.snapped = 1'b0;
    if (op == OpQuantize) begin
      g = nearest_grid(pos, m_div);
      if (m_swing > 0 && m_div >= 2) begin
        e = ((pos << 1) + 32768) >>> 16;
        if (e[0] == 1'b0) g += (m_swing + m_div / 2) / m_div;
      end
      if (m_groove_en && grv_cnt > 0) begin
        best = 65536;
        off = 0;
        for (int i = 0; i < grv_cnt; i++) begin
          diff = g - longint'(grv_pos[i]);
          if (diff < 0) diff = -diff;
          if (diff < best) begin
            best = diff;
            off = grv_off[i];
          end
        end
        g += div_away(off, m_div);
      end
      diff = g - pos;
      mag = (diff < 0) ? -diff : diff;
      if (mag * m_div <= m_tol) begin
        res = pos + div_away(diff * m_strength, 65536);
        if (res < 0) res = 0;
        if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
        r.qpos = res[31:0];
        r.snapped = 1'b1;
      end
    end else begin
      // Clip note: start, one-note skip, full table, offset threshold
      if (!(!clip_open && last)) begin
        if (!clip_open) begin
          clip_open = 1'b1;
          grv_cnt = 0;
        end
        if (last) clip_open = 1'b0;
        if (grv_cnt < NumPoints) begin
          g = nearest_grid(pos, m_div);
          off = (pos - g) * m_div;
          mag = (off < 0) ? -off : off;
          if (mag * 10 > 32768) begin
            grv_pos[grv_cnt] = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
            grv_off[grv_cnt] = off;
            grv_cnt++;
          end
        end
      end
    end
    r.count = grv_cnt[7:0];
    return r;
  endfunction

  // Send one word; valid stays high on return
  task automatic send_word(bit op, bit [31:0] pos, bit last);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = pos;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(predict_note(op, pos, last));
    words_sent++;
  endtask

  task automatic idle(int n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Random bursts with gaps
  task automatic send_paced(bit op, bit [31:0] pos, bit last);
    send_word(op, pos, last);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 30));
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic drain();
    idle(1);
    wait (result_q.size() == 0);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [mgq_pkg::CfgIdxW-1:0] idx, int unsigned val);
    longint v;
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[mgq_pkg::CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      mgq_pkg::REG_STRENGTH: begin
        v = longint'(val[16:0]);
        m_strength = (v > 65536) ? 65536 : v;
      end
      mgq_pkg::REG_SWING: begin
        v = longint'(val[15:0]);
        m_swing = (v > 32768) ? 32768 : v;
      end
      mgq_pkg::REG_TOLERANCE: begin
        v = longint'(val[15:0]);
        m_tol = (v < 655) ? 655 : ((v > 32768) ? 32768 : v);
      end
      mgq_pkg::REG_GRID_DIV: begin
        v = longint'(val[6:0]);
        m_div = (v < 1) ? 1 : ((v > 64) ? 64 : v);
      end
      mgq_pkg::REG_GROOVE_EN: m_groove_en = val[0];
      default: ;
    endcase
  endtask

  function automatic bit [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 70000);
      2: return $urandom_range(0, 3000);
      default: return $urandom_range(0, 16 * 65536);
    endcase
  endfunction

  // Defaults after reset and the named special cases
  task automatic test_directed();
    send_word(OpQuantize, 32'h0001_1000, 1'b0);
    send_word(OpQuantize, 32'h0000_0000, 1'b0);
    send_word(OpQuantize, 32'hFFFF_FFFF, 1'b0);
    send_word(OpQuantize, 32'h0000_8000, 1'b0);     // on a grid point
    send_word(OpExtract, 32'h0002_3000, 1'b1);      // one-note clip, ignored
    send_word(OpExtract, 32'h0000_6666, 1'b0);      // clip start
    send_word(OpExtract, 32'h0001_0100, 1'b0);      // below threshold, dropped
    send_word(OpQuantize, 32'h0000_4100, 1'b0);     // quantize mid clip
    send_word(OpExtract, 32'hFFFF_FFF0, 1'b1);      // grid above range
    drain();
    write_reg(mgq_pkg::REG_GROOVE_EN, 1);
    write_reg(mgq_pkg::REG_STRENGTH, 65536);
    send_word(OpQuantize, 32'h0000_4100, 1'b0);
    send_word(OpQuantize, 32'hFFFF_FF00, 1'b0);
    drain();
    // negative groove pulls a note at zero below zero
    write_reg(mgq_pkg::REG_GRID_DIV, 2);
    send_word(OpExtract, 32'h0000_6666, 1'b0);
    send_word(OpExtract, 32'h0003_0000, 1'b1);
    send_word(OpQuantize, 32'h0000_0000, 1'b0);
    send_word(OpQuantize, 32'h0000_0010, 1'b0);
    drain();
  endtask

  // Extremes and clamping of every register
  task automatic test_reg_extremes();
    logic [mgq_pkg::CfgIdxW-1:0] idx [12];
    int unsigned val [12];
    idx = '{mgq_pkg::REG_STRENGTH, mgq_pkg::REG_STRENGTH, mgq_pkg::REG_SWING,
            mgq_pkg::REG_SWING, mgq_pkg::REG_TOLERANCE, mgq_pkg::REG_TOLERANCE,
            mgq_pkg::REG_GRID_DIV, mgq_pkg::REG_GRID_DIV, mgq_pkg::REG_GRID_DIV,
            mgq_pkg::REG_GROOVE_EN, RegUnused, mgq_pkg::REG_TOLERANCE};
    val = '{32'h0, 32'h1FFFF, 32'd32768, 32'hFFFF, 32'd0, 32'd32768,
            32'd0, 32'd64, 32'h7F, 32'd0, 32'h1FFFF, 32'hFFFF};
    for (int k = 0; k < 12; k++) begin
      write_reg(idx[k], val[k]);
      repeat (3) send_word(OpQuantize, rand_pos(), 1'b0);
      drain();
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    long_hold = 400;
    repeat (6) send_word(OpQuantize, rand_pos(), 1'b0);
    drain();
  endtask

  // Clip overflow: more notes than the table holds
  task automatic test_table_full();
    write_reg(mgq_pkg::REG_GRID_DIV, 4);
    for (int i = 0; i < NumPoints + 6; i++)
      send_paced(OpExtract, i * 65536 + 32'h0000_1800, i == NumPoints + 5);
    drain();
    write_reg(mgq_pkg::REG_GROOVE_EN, 1);
    repeat (4) send_paced(OpQuantize, rand_pos(), 1'b0);
    drain();
  endtask

  task automatic test_random();
    int n, len;
    bit [31:0] p;
    n = 0;
    while (n < 1250) begin
      drain();
      if ($urandom_range(0, 4) == 0) begin
        write_reg(mgq_pkg::REG_STRENGTH, $urandom());
        write_reg(mgq_pkg::REG_SWING, $urandom());
        write_reg(mgq_pkg::REG_TOLERANCE, $urandom());
        write_reg(mgq_pkg::REG_GRID_DIV, $urandom());
      end else begin
        write_reg(mgq_pkg::REG_STRENGTH,
                  $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 65536));
        write_reg(mgq_pkg::REG_SWING,
                  $urandom_range(0, 1) ? 0 : $urandom_range(0, 32768));
        write_reg(mgq_pkg::REG_TOLERANCE, $urandom_range(655, 32768));
        write_reg(mgq_pkg::REG_GRID_DIV, $urandom_range(0, 3) == 0 ? $urandom_range(1, 64)
                                                                   : $urandom_range(1, 8));
      end
      write_reg(mgq_pkg::REG_GROOVE_EN, ($urandom_range(0, 3) != 0) ? 1 : 0);
      repeat (6) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            // well-formed clip of random notes, quantizes sometimes mixed in
            len = $urandom_range(2, 12);
            for (int i = 0; i < len; i++) begin
              p = $urandom_range(0, 16 * 65536);
              send_paced(OpExtract, p, i == len - 1);
              n++;
              if ($urandom_range(0, 5) == 0) begin
                send_paced(OpQuantize, rand_pos(), 1'b0);
                n++;
              end
            end
          end
          2: begin
            send_paced(OpExtract, rand_pos(), $urandom_range(0, 1) == 1);
            n++;
          end
          default: begin
            repeat ($urandom_range(2, 10)) begin
              send_paced(OpQuantize, rand_pos(), $urandom_range(0, 1) == 1);
              n++;
            end
          end
        endcase
      end
    end
    drain();
  endtask

  initial begin
    m_strength = 52429;
    m_swing = 0;
    m_tol = 16384;
    m_div = 4;
    m_groove_en = 1'b0;
    grv_cnt = 0;
    clip_open = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_reg_extremes();
    test_backpressure();
    test_table_full();
    test_random();
    $display("Sent %0d words, checked %0d results (%0d snapped), across",
             words_sent, words_checked, snaps_seen);
    $display("register extremes, clips, table overflow and receiver stalls.");
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
